// ----- rtl/core/lwad_pkg.sv -----
// ----------------------------------------------------------------------------
// lwad_pkg
// Shared widths, register indexes, CORDIC constants and the command and
// status bundles between the wall angle controller and its datapath.
// ----------------------------------------------------------------------------
package lwad_pkg;

  localparam int IDX_W    = 10;
  localparam int RNG_W    = 16;
  localparam int RUN_W    = 10;
  localparam int MARGIN_W = 6;
  localparam int ANG_W    = 16;
  localparam int CNT_W    = 16;
  localparam int CFG_IW   = 3;
  localparam int CFG_DW   = 16;

  // Signed beam position, wide enough for run points before beam zero.
  localparam int PW = 14;
  // CORDIC coordinate and angle accumulator widths.
  localparam int XW = 40;
  localparam int ZW = 34;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W = 4;

  localparam logic [RNG_W-1:0] GAIN_Q16 = 16'd39797;

  localparam logic [CFG_IW-1:0] CFG_NEAR_LIMIT   = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_JUMP_LIMIT   = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_MIN_RUN      = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_WINDOW_FIRST = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_WINDOW_LAST  = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_END_MARGIN   = 3'd5;

  localparam logic [RNG_W-1:0]    NEAR_LIMIT_RST   = 16'd700;
  localparam logic [RNG_W-1:0]    JUMP_LIMIT_RST   = 16'd50;
  localparam logic [RUN_W-1:0]    MIN_RUN_RST      = 10'd60;
  localparam logic [IDX_W-1:0]    WINDOW_FIRST_RST = 10'd284;
  localparam logic [IDX_W-1:0]    WINDOW_LAST_RST  = 10'd483;
  localparam logic [MARGIN_W-1:0] END_MARGIN_RST   = 6'd10;

  // Arctangent of 2^-i in 0.01 degree scaled by 2^16.
  function automatic logic [29:0] atan_q(input logic [STEP_W-1:0] i);
    logic [29:0] v;
    case (i)
      4'd0:  v = 30'd294912000;
      4'd1:  v = 30'd174096719;
      4'd2:  v = 30'd91987925;
      4'd3:  v = 30'd46694507;
      4'd4:  v = 30'd23437865;
      4'd5:  v = 30'd11730358;
      4'd6:  v = 30'd5866610;
      4'd7:  v = 30'd2933484;
      4'd8:  v = 30'd1466764;
      4'd9:  v = 30'd733385;
      4'd10: v = 30'd366693;
      4'd11: v = 30'd183346;
      4'd12: v = 30'd91673;
      4'd13: v = 30'd45837;
      4'd14: v = 30'd22918;
      default: v = 30'd11459;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic capture;
    logic check;
    logic run_inc;
    logic run_clr;
    logic rd_pt;
    logic pt_sel;
    logic ld_rot;
    logic step;
    logic save_pt;
    logic ld_vec;
    logic finish;
  } lwad_cmd_t;

  typedef struct packed {
    logic clr_busy;
    logic win_near;
    logic extend;
    logic long_run;
    logic iter_last;
    logic out_free;
  } lwad_sts_t;

endpackage

// ----- rtl/core/lwad_if.sv -----
// ----------------------------------------------------------------------------
// lwad_in_if / lwad_out_if
// Valid/ready channels for range samples and wall results.
// ----------------------------------------------------------------------------
interface lwad_in_if import lwad_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] beam_index;
  logic [RNG_W-1:0] range_mm;
  modport source (output valid, output beam_index, output range_mm, input ready);
  modport sink (input valid, input beam_index, input range_mm, output ready);
endinterface

interface lwad_out_if import lwad_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] wall_angle_cdeg;
  logic [CNT_W-1:0]        detect_count;
  modport source (output valid, output wall_angle_cdeg, output detect_count, input ready);
  modport sink (input valid, input wall_angle_cdeg, input detect_count, output ready);
endinterface

// ----- rtl/core/lwad_dp.sv -----
// ----------------------------------------------------------------------------
// lwad_dp
// Datapath: configuration registers, range store with its clearing pass,
// run state, shared iterative CORDIC and the output register.
// ----------------------------------------------------------------------------
module lwad_dp import lwad_pkg::*; #(
  parameter int BEAMS = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IW-1:0]       cfg_index,
  input  logic [CFG_DW-1:0]       cfg_wdata,
  input  logic [IDX_W-1:0]        in_beam_index,
  input  logic [RNG_W-1:0]        in_range_mm,
  input  lwad_cmd_t               cmd,
  output lwad_sts_t               sts,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic signed [ANG_W-1:0] out_wall_angle_cdeg,
  output logic [CNT_W-1:0]        out_detect_count
);

  localparam int AW = $clog2(BEAMS);
  localparam logic signed [PW-1:0] BEAMS_S = PW'(BEAMS);
  localparam logic signed [ZW-1:0] Z_HALF_TURN = ZW'(64'sd1179648000);
  localparam logic signed [ZW-1:0] Z_ROUND = ZW'(64'sd32768);

  function automatic logic [AW-1:0] wrap(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] q;
    q = p;
    if (q < 0) q = q + BEAMS_S;
    if (q < 0) q = q + BEAMS_S;
    if (q >= BEAMS_S) q = q - BEAMS_S;
    if (q >= BEAMS_S) q = q - BEAMS_S;
    return q[AW-1:0];
  endfunction

  logic [RNG_W-1:0]    near_r, jump_r;
  logic [RUN_W-1:0]    min_run_r, run_r;
  logic [IDX_W-1:0]    first_r, last_r, n_r;
  logic [MARGIN_W-1:0] margin_r;
  logic [RNG_W-1:0]    r_r;
  logic [RNG_W-1:0]    store [BEAMS];
  logic [RNG_W-1:0]    rd_data_r;
  logic                clr_busy_r;
  logic [AW-1:0]       clr_addr_r;
  logic [AW-1:0]       rd_addr, cur_addr, prev_addr;

  logic signed [PW-1:0] n_s, p0, p1, pt;
  logic signed [17:0]   cdeg, a1, a2;
  logic                 flip_nxt, flip_r, rot_r, zero_r;
  logic [31:0]          prod;

  logic signed [XW-1:0] x_r, y_r, x0_r, y0_r, x1_r, y1_r;
  logic signed [XW-1:0] xs, ys, dx, dy, sx, sy;
  logic signed [ZW-1:0] z_r, at, rz;
  logic [STEP_W-1:0]    iter_r;
  logic                 pos;

  logic                    out_valid_r;
  logic signed [ANG_W-1:0] out_ang_r;
  logic [CNT_W-1:0]        cnt_r, out_cnt_r;
  logic signed [ANG_W-1:0] ang;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r    <= NEAR_LIMIT_RST;
      jump_r    <= JUMP_LIMIT_RST;
      min_run_r <= MIN_RUN_RST;
      first_r   <= WINDOW_FIRST_RST;
      last_r    <= WINDOW_LAST_RST;
      margin_r  <= END_MARGIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NEAR_LIMIT:   near_r    <= cfg_wdata;
        CFG_JUMP_LIMIT:   jump_r    <= cfg_wdata;
        CFG_MIN_RUN:      min_run_r <= cfg_wdata[RUN_W-1:0];
        CFG_WINDOW_FIRST: first_r   <= cfg_wdata[IDX_W-1:0];
        CFG_WINDOW_LAST:  last_r    <= cfg_wdata[IDX_W-1:0];
        CFG_END_MARGIN:   margin_r  <= cfg_wdata[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      n_r <= in_beam_index;
      r_r <= in_range_mm;
    end
  end

  // Beam positions of the current sample, its neighbor and the run points.
  always_comb begin
    n_s       = PW'({1'b0, n_r});
    cur_addr  = wrap(n_s);
    prev_addr = wrap(n_s - PW'(1));
    p0        = n_s - PW'({1'b0, margin_r});
    p1        = n_s + PW'({1'b0, margin_r}) - PW'({1'b0, run_r});
    pt        = cmd.pt_sel ? p1 : p0;
    rd_addr   = cmd.rd_pt ? wrap(pt) : prev_addr;
  end

  // The store is swept to zero once after reset, one entry a cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(BEAMS - 1)) clr_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      store[clr_addr_r] <= '0;
    end else if (cmd.check && sts.win_near) begin
      store[cur_addr] <= r_r;
    end
    rd_data_r <= store[rd_addr];
  end

  // Angle reduction of the beam direction to [-90, 90] degrees.
  always_comb begin
    cdeg = 18'(pt) * 18'sd35 - 18'sd4535;
    if (cdeg >= 18'sd18000) a1 = cdeg - 18'sd36000;
    else if (cdeg < -18'sd18000) a1 = cdeg + 18'sd36000;
    else a1 = cdeg;
    flip_nxt = 1'b0;
    a2 = a1;
    if (a1 > 18'sd9000) begin
      a2 = a1 - 18'sd18000;
      flip_nxt = 1'b1;
    end else if (a1 < -18'sd9000) begin
      a2 = a1 + 18'sd18000;
      flip_nxt = 1'b1;
    end
    prod = rd_data_r * GAIN_Q16;
  end

  always_comb begin
    xs  = x_r >>> iter_r;
    ys  = y_r >>> iter_r;
    at  = ZW'(atan_q(iter_r));
    // Rotation follows the residual angle, vectoring the sign of y.
    pos = rot_r ? !z_r[ZW-1] : y_r[XW-1];
    sx  = flip_r ? -x_r : x_r;
    sy  = flip_r ? -y_r : y_r;
    dx  = x1_r - x0_r;
    dy  = y1_r - y0_r;
    rz  = (z_r + Z_ROUND) >>> 16;
    if (zero_r) ang = '0;
    else if (rz > ZW'(18000)) ang = 16'sd18000;
    else if (rz < -ZW'(18000)) ang = -16'sd18000;
    else ang = rz[ANG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_rot) begin
      x_r    <= XW'(prod);
      y_r    <= '0;
      z_r    <= ZW'(a2) <<< 16;
      flip_r <= flip_nxt;
      rot_r  <= 1'b1;
      iter_r <= '0;
    end else if (cmd.ld_vec) begin
      rot_r  <= 1'b0;
      iter_r <= '0;
      zero_r <= (dx == '0) && (dy == '0);
      if (dx < 0) begin
        x_r <= -dx;
        y_r <= -dy;
        z_r <= (dy >= 0) ? Z_HALF_TURN : -Z_HALF_TURN;
      end else begin
        x_r <= dx;
        y_r <= dy;
        z_r <= '0;
      end
    end else if (cmd.step) begin
      iter_r <= iter_r + STEP_W'(1);
      if (pos) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
    if (cmd.save_pt) begin
      if (cmd.pt_sel) begin
        x1_r <= sx;
        y1_r <= sy;
      end else begin
        x0_r <= sx;
        y0_r <= sy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.run_inc && run_r != '1) run_r <= run_r + RUN_W'(1);
      else if (cmd.run_clr || cmd.finish) run_r <= '0;
      if (cmd.finish) begin
        cnt_r       <= cnt_r + CNT_W'(1);
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_ang_r <= ang;
      out_cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_comb begin
    sts.clr_busy  = clr_busy_r;
    sts.win_near  = (n_r >= first_r) && (n_r <= last_r) && (r_r < near_r);
    sts.extend    = ($signed({1'b0, r_r}) - $signed({1'b0, rd_data_r}) <
                     $signed({1'b0, jump_r})) && (n_r != last_r);
    sts.long_run  = run_r >= min_run_r;
    sts.iter_last = iter_r == STEP_W'(CORDIC_STEPS - 1);
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid           = out_valid_r;
  assign out_wall_angle_cdeg = out_ang_r;
  assign out_detect_count    = out_cnt_r;

`ifndef NO_ASSERTIONS
  // A result is only produced into a free output slot.
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> sts.out_free) else $error("result loaded over a pending one");
  // Every reported wall advances the count by exactly one.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> cnt_r == $past(cnt_r) + CNT_W'(1)) else $error("count slip");
  // The reported angle stays within a half turn.
  a_ang_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_ang_r <= 16'sd18000 && out_ang_r >= -16'sd18000))
    else $error("angle out of range");
  // No sample is examined while the store is being cleared.
  a_clr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !cmd.capture && !cmd.check) else $error("work during clear");
`endif

endmodule

// ----- rtl/core/lwad_ctrl.sv -----
// ----------------------------------------------------------------------------
// lwad_ctrl
// Sequencer: run test, two point rotations and one vectoring pass per wall.
// ----------------------------------------------------------------------------
module lwad_ctrl import lwad_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  lwad_sts_t sts,
  output lwad_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_PREV, S_RD, S_LD, S_ROT, S_SAVE, S_VLD, S_VEC, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   sel_r, sel_nxt;

  always_comb begin
    state_nxt   = state_r;
    sel_nxt     = sel_r;
    cmd         = '0;
    cmd.pt_sel  = sel_r;
    in_ready    = (state_r == S_IDLE) && !sts.clr_busy;
    cmd.capture = in_valid && in_ready;
    unique case (state_r)
      S_IDLE: if (cmd.capture) state_nxt = S_CHECK;
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.win_near ? S_PREV : S_IDLE;
      end
      S_PREV: begin
        if (sts.extend) begin
          cmd.run_inc = 1'b1;
          state_nxt   = S_IDLE;
        end else if (!sts.long_run) begin
          cmd.run_clr = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          sel_nxt   = 1'b0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_pt = 1'b1;
        state_nxt = S_LD;
      end
      S_LD: begin
        cmd.ld_rot = 1'b1;
        state_nxt  = S_ROT;
      end
      S_ROT: begin
        cmd.step = 1'b1;
        if (sts.iter_last) state_nxt = S_SAVE;
      end
      S_SAVE: begin
        cmd.save_pt = 1'b1;
        if (sel_r) begin
          state_nxt = S_VLD;
        end else begin
          sel_nxt   = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_VLD: begin
        cmd.ld_vec = 1'b1;
        state_nxt  = S_VEC;
      end
      S_VEC: begin
        cmd.step = 1'b1;
        if (sts.iter_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

endmodule

// ----- rtl/core/lidar_wall_angle_detector_top.sv -----
// ----------------------------------------------------------------------------
// lidar_wall_angle_detector_top
// Finds straight runs of near lidar samples and reports their wall angle.
//
//   channel  | dir | payload
//   in_chan  | in  | beam_index[9:0], range_mm[15:0]
//   out_chan | out | wall_angle_cdeg[15:0] signed, detect_count[15:0]
//   cfg_*    | in  | cfg_we, cfg_index[2:0], cfg_wdata[15:0]
//
// A sample outside the window or at or beyond the near limit ends after the
// window test, any other sample that reports no wall after the run test; one
// that reports a wall runs the shared 16-step CORDIC three times in turn. No
// new sample is taken before the last is done; after reset the range store
// is cleared before the first transfer is taken; configuration writes are
// taken throughout. A finished result waits in the output register; a
// further result stalls the sequencer until that register is free.
// ----------------------------------------------------------------------------
module lidar_wall_angle_detector_top import lwad_pkg::*; #(
  parameter int BEAMS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  lwad_in_if.sink           in_chan,
  lwad_out_if.source        out_chan
);

  lwad_cmd_t cmd;
  lwad_sts_t sts;

  lwad_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lwad_dp #(.BEAMS(BEAMS)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_beam_index       (in_chan.beam_index),
    .in_range_mm         (in_chan.range_mm),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_ready           (out_chan.ready),
    .out_valid           (out_chan.valid),
    .out_wall_angle_cdeg (out_chan.wall_angle_cdeg),
    .out_detect_count    (out_chan.detect_count)
  );

endmodule

// ----- sim/lidar_wall_angle_detector_top_tb.sv -----
// ----------------------------------------------------------------------------
// lidar_wall_angle_detector_top_tb
// Self-checking bench for the lidar wall angle detector. Samples go in as
// directed edge cases and then as random scans across several register
// settings. A bit-true wall angle predictor runs on every accepted sample,
// and each result transfer is compared with the oldest predicted wall.
// ----------------------------------------------------------------------------
module lidar_wall_angle_detector_top_tb;
  import lwad_pkg::*;

  localparam int NBEAMS = 1024;
  localparam int SETTLE = 80;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [IDX_W-1:0] beam;
    logic [RNG_W-1:0] rng;
  } sample_t;

  typedef struct {
    logic signed [ANG_W-1:0] angle;
    logic [CNT_W-1:0]        count;
  } wall_t;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  lwad_in_if  in_chan();
  lwad_out_if out_chan();

  lidar_wall_angle_detector_top #(.BEAMS(NBEAMS)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_chan(in_chan), .out_chan(out_chan)
  );

  sample_t    sample_q[$];
  wall_t      wall_q[$];
  idle_mode_t idle_mode = IDLE_NONE;
  bit         hold_send = 1'b0;
  int         errors = 0;
  longint     cycles = 0;

  // Predictor state and register copies.
  logic [RNG_W-1:0]    shadow_store[NBEAMS];
  int                  run_len;
  logic [CNT_W-1:0]    wall_cnt;
  logic [RNG_W-1:0]    near_lim, jump_lim;
  logic [RUN_W-1:0]    min_run_len;
  logic [IDX_W-1:0]    win_first, win_last;
  logic [MARGIN_W-1:0] margin;

  initial begin
    in_chan.valid = 1'b0;
    in_chan.beam_index = '0;
    in_chan.range_mm = '0;
    out_chan.ready = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint atan_step(int i);
    longint t[16] = '{294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
                      5866610, 2933484, 1466764, 733385, 366693, 183346, 91673,
                      45837, 22918, 11459};
    return t[i];
  endfunction

  // Rotation CORDIC: point at distance d along beam angle cdeg, Q16 mm.
  function automatic void beam_point(input longint d, input int cdeg,
                                     output longint xo, output longint yo);
    int a;
    bit flip;
    longint x, y, z, xs, ys;
    a = cdeg % 36000;
    flip = 1'b0;
    if (a >= 18000) a -= 36000;
    if (a < -18000) a += 36000;
    if (a > 9000) begin
      a -= 18000;
      flip = 1'b1;
    end else if (a < -9000) begin
      a += 18000;
      flip = 1'b1;
    end
    x = d * 39797;
    y = 0;
    z = longint'(a) * 65536;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_step(i);
      end else begin
        x += ys; y -= xs; z += atan_step(i);
      end
    end
    xo = flip ? -x : x;
    yo = flip ? -y : y;
  endfunction

  // Vectoring CORDIC: direction of (dx, dy) in 0.01 degree.
  function automatic int wall_direction(longint dy, longint dx);
    longint x, y, z, xs, ys, r;
    if (dx == 0 && dy == 0) return 0;
    x = dx; y = dy; z = 0;
    if (dx < 0) begin
      x = -dx; y = -dy;
      z = (dy >= 0) ? 64'sd18000 * 65536 : -64'sd18000 * 65536;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_step(i);
      end else begin
        x -= ys; y += xs; z -= atan_step(i);
      end
    end
    r = (z + 32768) >>> 16;
    if (r > 18000) r = 18000;
    if (r < -18000) r = -18000;
    return int'(r);
  endfunction

  // Applies one accepted sample; queues the wall it reports, if any.
  function automatic void predict_wall(sample_t s);
    int n, diff, p0, p1;
    logic [IDX_W-1:0] a0, a1;
    longint x0, y0, x1, y1;
    wall_t w;
    n = s.beam;
    if (s.beam < win_first || s.beam > win_last) return;
    if (s.rng >= near_lim) return;
    shadow_store[s.beam] = s.rng;
    diff = int'(s.rng) - int'(shadow_store[s.beam - 10'd1]);
    if (diff < int'(jump_lim) && s.beam != win_last) begin
      if (run_len < 1023) run_len++;
      return;
    end
    if (run_len < int'(min_run_len)) begin
      run_len = 0;
      return;
    end
    p0 = n - int'(margin);
    p1 = n + int'(margin) - run_len;
    a0 = p0[IDX_W-1:0];
    a1 = p1[IDX_W-1:0];
    beam_point(longint'(shadow_store[a0]), 35 * p0 - 4535, x0, y0);
    beam_point(longint'(shadow_store[a1]), 35 * p1 - 4535, x1, y1);
    w.angle = ANG_W'(wall_direction(y1 - y0, x1 - x0));
    run_len = 0;
    wall_cnt = wall_cnt + 1'b1;
    w.count = wall_cnt;
    wall_q.push_back(w);
  endfunction

  // Sample driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (sample_q.size() > 0 && !hold_send &&
          !((idle_mode == IDLE_SEND && $urandom_range(99) < 57) ||
            (idle_mode == IDLE_BOTH && $urandom_range(99) < 25))) begin
        in_chan.beam_index <= sample_q[0].beam;
        in_chan.range_mm   <= sample_q[0].rng;
        in_chan.valid      <= 1'b1;
        void'(sample_q.pop_front());
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // Result acceptance.
  always @(posedge clk) begin
    if (!rst_n) out_chan.ready <= 1'b0;
    else if (idle_mode == IDLE_RECV) out_chan.ready <= $urandom_range(99) >= 57;
    else if (idle_mode == IDLE_BOTH) out_chan.ready <= $urandom_range(99) >= 25;
    else out_chan.ready <= 1'b1;
  end

  // Prediction on input transfers, checking on output transfers.
  always @(posedge clk) begin
    wall_t w;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready)
        predict_wall('{in_chan.beam_index, in_chan.range_mm});
      if (out_chan.valid && out_chan.ready) begin
        if (wall_q.size() == 0) begin
          $error("unexpected wall result: angle %0d count %0d",
                 out_chan.wall_angle_cdeg, out_chan.detect_count);
          errors++;
        end else begin
          w = wall_q.pop_front();
          if (out_chan.wall_angle_cdeg !== w.angle) begin
            $error("wall_angle_cdeg expected %0d actual %0d", w.angle,
                   out_chan.wall_angle_cdeg);
            errors++;
          end
          if (out_chan.detect_count !== w.count) begin
            $error("detect_count expected %0d actual %0d", w.count,
                   out_chan.detect_count);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_NEAR_LIMIT:   near_lim    = val;
      CFG_JUMP_LIMIT:   jump_lim    = val;
      CFG_MIN_RUN:      min_run_len = val[RUN_W-1:0];
      CFG_WINDOW_FIRST: win_first   = val[IDX_W-1:0];
      CFG_WINDOW_LAST:  win_last    = val[IDX_W-1:0];
      CFG_END_MARGIN:   margin      = val[MARGIN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(int nl, int jl, int mr, int wf, int wl, int em);
    write_reg(CFG_NEAR_LIMIT, CFG_DW'(nl));
    write_reg(CFG_JUMP_LIMIT, CFG_DW'(jl));
    write_reg(CFG_MIN_RUN, CFG_DW'(mr));
    write_reg(CFG_WINDOW_FIRST, CFG_DW'(wf));
    write_reg(CFG_WINDOW_LAST, CFG_DW'(wl));
    write_reg(CFG_END_MARGIN, CFG_DW'(em));
  endtask

  // Waits until every sample is taken and every wall has arrived, then lets
  // the block finish any sample that reports nothing.
  task automatic drain();
    while (sample_q.size() > 0 || in_chan.valid || wall_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic add_sample(int beam, int rng);
    sample_q.push_back('{beam[IDX_W-1:0], rng[RNG_W-1:0]});
  endtask

  // One scan over a beam span: mostly smooth near surfaces, with jumps,
  // far returns and out-of-order noise mixed in.
  task automatic add_scan(int first, int last, int top);
    int r, k;
    r = (top > 60) ? $urandom_range(top - 1, top / 3) : 0;
    for (int n = first; n <= last; n++) begin
      k = $urandom_range(99);
      if (k < 82) r = r + $urandom_range(24) - 16;
      else if (k < 88) r = r + $urandom_range(400, 60);
      else if (k < 92) r = $urandom_range(top - 1 > 0 ? top - 1 : 0);
      if (r < 0) r = 0;
      if (r > 65535) r = 65535;
      if (k >= 92 && k < 96) add_sample(n, 65535);
      else if (k >= 96) add_sample($urandom_range(1023), $urandom_range(65535));
      else add_sample(n, r);
    end
  endtask

  initial begin
    for (int i = 0; i < NBEAMS; i++) shadow_store[i] = '0;
    run_len = 0;
    wall_cnt = '0;
    near_lim = NEAR_LIMIT_RST;
    jump_lim = JUMP_LIMIT_RST;
    min_run_len = MIN_RUN_RST;
    win_first = WINDOW_FIRST_RST;
    win_last = WINDOW_LAST_RST;
    margin = END_MARGIN_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed edges at the reset settings.
    add_sample(0, 0);
    add_sample(1023, 65535);
    add_sample(283, 100);
    add_sample(484, 100);
    add_sample(284, 0);
    add_sample(285, 699);
    add_sample(286, 700);
    add_sample(287, 65535);
    add_sample(288, 649);
    add_sample(289, 600);
    add_sample(483, 10);
    add_sample(483, 699);
    add_sample(300, 21845);
    add_sample(301, 43690);
    add_sample(302, 1);
    add_sample(303, 51);
    add_sample(304, 2);
    drain();

    // Wall scan at the reset geometry.
    add_scan(284, 483, 700);
    idle_mode = IDLE_SEND;
    add_scan(284, 383, 700);
    drain();

    // Wide open with a moderate jump limit: one long run wraps from the top
    // beams through beam zero, so its far run point lies before beam zero.
    set_regs(65535, 2000, 1, 0, 1023, 63);
    idle_mode = IDLE_RECV;
    add_sample(1023, 1990);
    for (int n = 850; n < 1023; n++) add_sample(n, 3000 - n);
    for (int n = 0; n < 100; n++) add_sample(n, 1990 - n);
    add_sample(100, 6000);
    drain();

    // Nothing is near; the window spans the whole index range, minimum run at its top.
    set_regs(0, 0, 1023, 0, 1023, 0);
    idle_mode = IDLE_BOTH;
    for (int i = 0; i < 20; i++) add_sample($urandom_range(1023), $urandom_range(65535));
    drain();

    // Zero jump limit and zero run length: only strictly falling runs extend,
    // every run end reports.
    set_regs(2000, 0, 0, 100, 150, 0);
    add_scan(100, 150, 2000);
    hold_send = 1'b1;
    while (wall_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    hold_send = 1'b0;
    add_scan(100, 150, 2000);
    add_scan(100, 150, 2000);
    drain();

    // Empty window.
    set_regs(1000, 200, 5, 500, 499, 7);
    idle_mode = IDLE_NONE;
    for (int i = 0; i < 20; i++) add_sample($urandom_range(1023), $urandom_range(1500));
    drain();

    // High end of the index range.
    set_regs(1500, 100, 8, 960, 1023, 3);
    add_scan(960, 1023, 1500);
    idle_mode = IDLE_BOTH;
    add_scan(960, 1023, 1500);
    drain();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
